// File: rtl/dmwbc_pkg.sv
// Package for the direct-mapped write-back cache core.
// Holds the controller/datapath command and status types and the cost constants.
// No dependencies.
package dmwbc_pkg;

	// Default geometry
	localparam int DEF_INDEX_BITS  = 4;
	localparam int DEF_OFFSET_BITS = 2;
	localparam int DEF_TAG_BITS    = 2;
	localparam int DEF_WORD_BITS   = 32;

	// Width of the running cycle total
	localparam int CYCLE_BITS = 32;

	// Modeled access costs
	localparam logic [CYCLE_BITS-1:0] COST_ACCESS         = CYCLE_BITS'(1);
	localparam logic [CYCLE_BITS-1:0] COST_FILL           = CYCLE_BITS'(13);
	localparam logic [CYCLE_BITS-1:0] COST_WRITEBACK      = CYCLE_BITS'(12);
	localparam logic [CYCLE_BITS-1:0] COST_UNCACHED_WRITE = CYCLE_BITS'(3);

	// Datapath operations issued by the controller
	typedef enum logic [2:0] {
		OP_NONE,
		OP_CLEAR,
		OP_CAPTURE,
		OP_LOOK,
		OP_WBACK,
		OP_FILL,
		OP_LINE,
		OP_RESP
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic step_done;
		logic cached;
		logic hit;
		logic victim_dirty;
	} dp_status_t;

endpackage

// File: rtl/dmwbc_if.sv
// Valid/ready channel interfaces of the cache core: request and response words.
// Uses dmwbc_pkg for the cycle total width.
interface dmwbc_req_if #(
	parameter int ADDR_BITS = 8,
	parameter int WORD_BITS = 32
);
	logic                 valid;
	logic                 ready;
	logic                 func;
	logic [ADDR_BITS-1:0] address;
	logic [WORD_BITS-1:0] write_data;
	logic                 use_cache;

	modport source (output valid, func, address, write_data, use_cache, input ready);
	modport sink (input valid, func, address, write_data, use_cache, output ready);
endinterface

interface dmwbc_rsp_if #(
	parameter int WORD_BITS = 32
);
	import dmwbc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [WORD_BITS-1:0]  read_data;
	logic                  hit;
	logic                  wrote_back;
	logic [CYCLE_BITS-1:0] cycle_total;

	modport source (output valid, read_data, hit, wrote_back, cycle_total, input ready);
	modport sink (input valid, read_data, hit, wrote_back, cycle_total, output ready);
endinterface

// File: rtl/direct_mapped_write_back_cache_core.sv
// Top level of the direct-mapped write-back cache core: controller plus datapath.
// Depends on dmwbc_pkg, dmwbc_if, dmwbc_ctrl and dmwbc_dpath.
//
//   channel  dir  handshake    word
//   req      in   valid/ready  func, address, write_data, use_cache
//   rsp      out  valid/ready  read_data, hit, wrote_back, cycle_total
//
// One access at a time. Uncached: accept, memory access, response.
// Cached hit: accept, tag lookup, line access, response.
// A miss adds a line fill before the line access, preceded by a write-back of a dirty victim;
// the words move one per cycle through the single-port main and line memories.
// After reset a clearing pass zeroes main memory; req.ready stays low meanwhile.
// A new request is taken while a response waits in the rsp register; it holds in the
// response step until that register frees.
module direct_mapped_write_back_cache_core #(
	parameter int INDEX_BITS  = dmwbc_pkg::DEF_INDEX_BITS,
	parameter int OFFSET_BITS = dmwbc_pkg::DEF_OFFSET_BITS,
	parameter int TAG_BITS    = dmwbc_pkg::DEF_TAG_BITS,
	parameter int WORD_BITS   = dmwbc_pkg::DEF_WORD_BITS
) (
	input logic         clk,
	input logic         arst_n,
	dmwbc_req_if.sink   req,
	dmwbc_rsp_if.source rsp
);
	import dmwbc_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;

	dmwbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.st        (st)
	);

	dmwbc_dpath #(
		.INDEX_BITS  (INDEX_BITS),
		.OFFSET_BITS (OFFSET_BITS),
		.TAG_BITS    (TAG_BITS),
		.WORD_BITS   (WORD_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.func        (req.func),
		.address     (req.address),
		.write_data  (req.write_data),
		.use_cache   (req.use_cache),
		.read_data   (rsp.read_data),
		.hit         (rsp.hit),
		.wrote_back  (rsp.wrote_back),
		.cycle_total (rsp.cycle_total)
	);

endmodule

// File: rtl/dmwbc_ctrl.sv
// Controller state machine of the cache core.
// Sequences clear, lookup, write-back, fill, line access and response; uses dmwbc_pkg.
module dmwbc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output dmwbc_pkg::dp_cmd_t    cmd,
	input  dmwbc_pkg::dp_status_t st
);
	import dmwbc_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_WBACK,
		S_FILL,
		S_LINE,
		S_RESP
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   load_out;

	assign load_out  = (state_q == S_RESP) && (!out_valid_q || out_ready);
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Operation for the datapath in the current state
	always_comb begin
		cmd.op = OP_NONE;
		unique case (state_q)
			S_CLEAR: cmd.op = OP_CLEAR;
			S_IDLE:  cmd.op = in_valid ? OP_CAPTURE : OP_NONE;
			S_LOOK:  cmd.op = OP_LOOK;
			S_WBACK: cmd.op = OP_WBACK;
			S_FILL:  cmd.op = OP_FILL;
			S_LINE:  cmd.op = OP_LINE;
			S_RESP:  cmd.op = load_out ? OP_RESP : OP_NONE;
			default: cmd.op = OP_NONE;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: if (st.clear_done) state_q <= S_IDLE;
				S_IDLE:  if (in_valid) state_q <= S_LOOK;
				S_LOOK: begin
					priority if (!st.cached)     state_q <= S_RESP;
					else if (st.hit)             state_q <= S_LINE;
					else if (st.victim_dirty)    state_q <= S_WBACK;
					else                         state_q <= S_FILL;
				end
				S_WBACK: if (st.step_done) state_q <= S_FILL;
				S_FILL:  if (st.step_done) state_q <= S_LINE;
				S_LINE:  state_q <= S_RESP;
				S_RESP:  if (load_out) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/dmwbc_dpath.sv
// Datapath of the cache core: main memory, line data memory, tag/valid/dirty flops,
// request and response registers, cycle total. Uses dmwbc_pkg.
module dmwbc_dpath #(
	parameter int INDEX_BITS  = dmwbc_pkg::DEF_INDEX_BITS,
	parameter int OFFSET_BITS = dmwbc_pkg::DEF_OFFSET_BITS,
	parameter int TAG_BITS    = dmwbc_pkg::DEF_TAG_BITS,
	parameter int WORD_BITS   = dmwbc_pkg::DEF_WORD_BITS
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  dmwbc_pkg::dp_cmd_t                          cmd,
	output dmwbc_pkg::dp_status_t                       st,
	input  logic                                        func,
	input  logic [TAG_BITS+INDEX_BITS+OFFSET_BITS-1:0]  address,
	input  logic [WORD_BITS-1:0]                        write_data,
	input  logic                                        use_cache,
	output logic [WORD_BITS-1:0]                        read_data,
	output logic                                        hit,
	output logic                                        wrote_back,
	output logic [dmwbc_pkg::CYCLE_BITS-1:0]            cycle_total
);
	import dmwbc_pkg::*;

	localparam int ADDR_BITS  = TAG_BITS + INDEX_BITS + OFFSET_BITS;
	localparam int SLOT_BITS  = INDEX_BITS + OFFSET_BITS;
	localparam int MAIN_DEPTH = 1 << ADDR_BITS;
	localparam int LINES      = 1 << INDEX_BITS;
	localparam int SLOTS      = 1 << SLOT_BITS;
	localparam int LINE_WORDS = 1 << OFFSET_BITS;

	// Memories
	logic [WORD_BITS-1:0] main_mem [MAIN_DEPTH];
	logic [WORD_BITS-1:0] line_mem [SLOTS];

	// Request registers
	logic                 func_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [WORD_BITS-1:0] wdata_q;
	logic                 cached_q;

	logic [TAG_BITS-1:0]    req_tag;
	logic [INDEX_BITS-1:0]  req_idx;
	logic [OFFSET_BITS-1:0] req_off;

	// Line state
	logic [TAG_BITS-1:0] tag_q [LINES];
	logic [LINES-1:0]    valid_q;
	logic [LINES-1:0]    dirty_q;

	// Sweep counters
	logic [ADDR_BITS:0]     clr_q;
	logic [OFFSET_BITS:0]   step_q;
	logic [OFFSET_BITS:0]   step_dec;
	logic [OFFSET_BITS-1:0] step_prev;
	logic                   step_done;

	// Memory ports
	logic                 main_we, main_re, line_we, line_re;
	logic [ADDR_BITS-1:0] main_waddr, main_raddr;
	logic [WORD_BITS-1:0] main_wdata, line_wdata;
	logic [SLOT_BITS-1:0] line_waddr, line_raddr;
	logic [WORD_BITS-1:0] main_rdata_q, line_rdata_q;

	// Access flags and result
	logic                  hit_q, wb_q;
	logic [CYCLE_BITS-1:0] cost;
	logic [WORD_BITS-1:0]  read_data_q;
	logic                  hit_out_q, wb_out_q;
	logic [CYCLE_BITS-1:0] cycle_q;

	assign req_off = addr_q[OFFSET_BITS-1:0];
	assign req_idx = addr_q[SLOT_BITS-1:OFFSET_BITS];
	assign req_tag = addr_q[ADDR_BITS-1:SLOT_BITS];

	assign step_dec  = step_q - 1'b1;
	assign step_prev = step_dec[OFFSET_BITS-1:0];
	assign step_done = (step_q == (OFFSET_BITS+1)'(LINE_WORDS));

	// Status to the controller
	assign st.clear_done   = clr_q[ADDR_BITS];
	assign st.step_done    = step_done;
	assign st.cached       = cached_q;
	assign st.hit          = valid_q[req_idx] && (tag_q[req_idx] == req_tag);
	assign st.victim_dirty = valid_q[req_idx] && dirty_q[req_idx];

	// Main memory port selection
	always_comb begin
		main_we    = 1'b0;
		main_waddr = '0;
		main_wdata = '0;
		main_re    = 1'b0;
		main_raddr = '0;
		unique case (cmd.op)
			OP_CLEAR: begin
				main_we    = !clr_q[ADDR_BITS];
				main_waddr = clr_q[ADDR_BITS-1:0];
			end
			OP_LOOK: begin
				if (!cached_q) begin
					main_we    = func_q;
					main_waddr = addr_q;
					main_wdata = wdata_q;
					main_re    = !func_q;
					main_raddr = addr_q;
				end
			end
			OP_WBACK: begin
				// victim goes back to its own line base, one word behind the line read
				main_we    = (step_q != '0);
				main_waddr = {tag_q[req_idx], req_idx, step_prev};
				main_wdata = line_rdata_q;
			end
			OP_FILL: begin
				main_re    = !step_done;
				main_raddr = {req_tag, req_idx, step_q[OFFSET_BITS-1:0]};
			end
			default: ;
		endcase
	end

	// Line memory port selection
	always_comb begin
		line_we    = 1'b0;
		line_waddr = '0;
		line_wdata = '0;
		line_re    = 1'b0;
		line_raddr = '0;
		unique case (cmd.op)
			OP_WBACK: begin
				line_re    = !step_done;
				line_raddr = {req_idx, step_q[OFFSET_BITS-1:0]};
			end
			OP_FILL: begin
				line_we    = (step_q != '0);
				line_waddr = {req_idx, step_prev};
				line_wdata = main_rdata_q;
			end
			OP_LINE: begin
				line_we    = func_q;
				line_waddr = {req_idx, req_off};
				line_wdata = wdata_q;
				line_re    = !func_q;
				line_raddr = {req_idx, req_off};
			end
			default: ;
		endcase
	end

	// Main memory
	always_ff @(posedge clk) begin
		if (main_we) main_mem[main_waddr] <= main_wdata;
		if (main_re) main_rdata_q <= main_mem[main_raddr];
	end

	// Line data memory
	always_ff @(posedge clk) begin
		if (line_we) line_mem[line_waddr] <= line_wdata;
		if (line_re) line_rdata_q <= line_mem[line_raddr];
	end

	// Counters, valid/dirty bits, cycle total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			step_q  <= '0;
			valid_q <= '0;
			dirty_q <= '0;
			cycle_q <= '0;
		end else begin
			if (cmd.op == OP_CLEAR && !clr_q[ADDR_BITS]) clr_q <= clr_q + 1'b1;
			if (cmd.op == OP_WBACK || cmd.op == OP_FILL) begin
				step_q <= step_done ? '0 : step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
			if (cmd.op == OP_FILL && step_done) begin
				valid_q[req_idx] <= 1'b1;
				dirty_q[req_idx] <= 1'b0;
			end
			if (cmd.op == OP_LINE && func_q) dirty_q[req_idx] <= 1'b1;
			if (cmd.op == OP_RESP) cycle_q <= cycle_q + cost;
		end
	end

	// Tags, request and result payload
	always_ff @(posedge clk) begin
		if (cmd.op == OP_FILL && step_done) tag_q[req_idx] <= req_tag;
		if (cmd.op == OP_CAPTURE) begin
			func_q   <= func;
			addr_q   <= address;
			wdata_q  <= write_data;
			cached_q <= use_cache;
		end
		if (cmd.op == OP_LOOK) begin
			hit_q <= cached_q && st.hit;
			wb_q  <= 1'b0;
		end
		if (cmd.op == OP_WBACK) wb_q <= 1'b1;
		if (cmd.op == OP_RESP) begin
			read_data_q <= func_q ? '0 : (cached_q ? line_rdata_q : main_rdata_q);
			hit_out_q   <= hit_q;
			wb_out_q    <= wb_q;
		end
	end

	// Modeled cost of the finished access
	always_comb begin
		cost = '0;
		if (cached_q) begin
			cost = COST_ACCESS + (hit_q ? '0 : COST_FILL) + (wb_q ? COST_WRITEBACK : '0);
		end else if (func_q) begin
			cost = COST_UNCACHED_WRITE;
		end
	end

	assign read_data   = read_data_q;
	assign hit         = hit_out_q;
	assign wrote_back  = wb_out_q;
	assign cycle_total = cycle_q;

endmodule

// File: rtl/dmwbc_checker.sv
// Port-level checker for the cache core, bound to the top level.
// Depends on dmwbc_pkg and direct_mapped_write_back_cache_core.
module dmwbc_checker #(
	parameter int WORD_BITS = dmwbc_pkg::DEF_WORD_BITS
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [WORD_BITS-1:0]            read_data,
	input logic                            hit,
	input logic                            wrote_back,
	input logic [dmwbc_pkg::CYCLE_BITS-1:0] cycle_total
);
	import dmwbc_pkg::*;

	// A stalled response stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("response dropped while stalled");

	// A stalled response word does not change
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(read_data) && $stable(hit) &&
			$stable(wrote_back) && $stable(cycle_total))
		else $error("response word changed while stalled");

	// One access at a time: no second request right after one is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while an access is in flight");

	// A hit never writes back a victim
	a_hit_no_wb: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && wrote_back))
		else $error("hit reported together with write-back");

endmodule

bind direct_mapped_write_back_cache_core dmwbc_checker #(
	.WORD_BITS (WORD_BITS)
) u_dmwbc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (req.valid),
	.in_ready    (req.ready),
	.out_valid   (rsp.valid),
	.out_ready   (rsp.ready),
	.read_data   (rsp.read_data),
	.hit         (rsp.hit),
	.wrote_back  (rsp.wrote_back),
	.cycle_total (rsp.cycle_total)
);

// File: test/tb_top.sv
// Self-checking testbench for direct_mapped_write_back_cache_core: random and directed accesses,
// a shadow copy of memory, cache lines and cycle total to predict every response word.
// Depends on dmwbc_pkg, dmwbc_if and the core RTL.
module tb_top;
	import dmwbc_pkg::*;

	localparam int ADDR_BITS       = DEF_TAG_BITS + DEF_INDEX_BITS + DEF_OFFSET_BITS;
	localparam int MAIN_DEPTH      = 1 << ADDR_BITS;
	localparam int LINES           = 1 << DEF_INDEX_BITS;
	localparam int LINE_WORDS      = 1 << DEF_OFFSET_BITS;
	localparam bit FUNC_READ       = 1'b0;
	localparam bit FUNC_WRITE      = 1'b1;
	localparam int RANDOM_ACCESSES = 1400;
	localparam int CYCLE_LIMIT     = 500000;
	localparam int HOLD_OFF_AFTER  = 400;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int SETTLE_CYCLES   = 40;

	typedef struct {
		logic                     func;
		logic [ADDR_BITS-1:0]     address;
		logic [DEF_WORD_BITS-1:0] write_data;
		logic                     use_cache;
		bit                       wait_idle;
	} access_t;

	typedef struct {
		logic [DEF_WORD_BITS-1:0] read_data;
		logic                     hit;
		logic                     wrote_back;
		logic [CYCLE_BITS-1:0]    cycle_total;
	} response_t;

	typedef enum int {
		STALL_NONE,
		STALL_SOME,
		STALL_HEAVY
	} stall_mode_t;

	logic clk;
	logic arst_n;

	dmwbc_req_if #(.ADDR_BITS(ADDR_BITS), .WORD_BITS(DEF_WORD_BITS)) req_ch ();
	dmwbc_rsp_if #(.WORD_BITS(DEF_WORD_BITS)) rsp_ch ();

	direct_mapped_write_back_cache_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow state of the cache and memory
	logic [DEF_WORD_BITS-1:0] main_mem [MAIN_DEPTH];
	logic [DEF_WORD_BITS-1:0] line_data [LINES*LINE_WORDS];
	logic [DEF_TAG_BITS-1:0]  line_tag [LINES];
	logic                     line_valid [LINES];
	logic                     line_dirty [LINES];
	logic [CYCLE_BITS-1:0]    access_cycles;

	access_t   pending_words [$];
	response_t expected_rsp [$];
	int        errors;
	int        responses_checked;
	int        cycle_count;

	// Driver and receiver state
	access_t     cur_word;
	int          burst_left;
	int          gap_left;
	bit          offer;
	stall_mode_t stall_mode;
	int          stall_left;
	int          hold_left;
	bit          hold_done;
	bit          rdy;

	// Apply one access to the shadow state, return the response it must produce
	function automatic response_t predict_access(input access_t a);
		response_t                r;
		logic [DEF_TAG_BITS-1:0]    tag;
		logic [DEF_INDEX_BITS-1:0]  idx;
		logic [DEF_OFFSET_BITS-1:0] off;
		logic [ADDR_BITS-1:0]       base;
		int                         slot;
		{tag, idx, off} = a.address;
		r.read_data  = '0;
		r.hit        = 1'b0;
		r.wrote_back = 1'b0;
		slot = idx * LINE_WORDS;
		if (a.use_cache) begin
			access_cycles += COST_ACCESS;
			if (line_valid[idx] && line_tag[idx] == tag) begin
				r.hit = 1'b1;
			end else begin
				// dirty victim goes back to its own line base first
				if (line_valid[idx] && line_dirty[idx]) begin
					base = {line_tag[idx], idx, {DEF_OFFSET_BITS{1'b0}}};
					for (int i = 0; i < LINE_WORDS; i++)
						main_mem[base + i] = line_data[slot + i];
					r.wrote_back = 1'b1;
					access_cycles += COST_WRITEBACK;
				end
				base = {tag, idx, {DEF_OFFSET_BITS{1'b0}}};
				for (int i = 0; i < LINE_WORDS; i++)
					line_data[slot + i] = main_mem[base + i];
				line_tag[idx]   = tag;
				line_valid[idx] = 1'b1;
				line_dirty[idx] = 1'b0;
				access_cycles += COST_FILL;
			end
			if (a.func == FUNC_WRITE) begin
				line_data[slot + off] = a.write_data;
				line_dirty[idx] = 1'b1;
			end else begin
				r.read_data = line_data[slot + off];
			end
		end else begin
			// uncached: memory only, cache untouched
			if (a.func == FUNC_WRITE) begin
				main_mem[a.address] = a.write_data;
				access_cycles += COST_UNCACHED_WRITE;
			end else begin
				r.read_data = main_mem[a.address];
			end
		end
		r.cycle_total = access_cycles;
		return r;
	endfunction

	function automatic access_t make_access(input bit func, input int address, input logic [31:0] data,
			input bit cached, input bit wait_idle);
		access_t a;
		a.func       = func;
		a.address    = address[ADDR_BITS-1:0];
		a.write_data = data;
		a.use_cache  = cached;
		a.wait_idle  = wait_idle;
		return a;
	endfunction

	// Clock, reset and known input levels from time zero
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_READ;
		req_ch.address = '0;
		req_ch.write_data = '0;
		req_ch.use_cache = 1'b0;
		rsp_ch.ready = 1'b0;
		for (int i = 0; i < MAIN_DEPTH; i++)
			main_mem[i] = '0;
		for (int i = 0; i < LINES*LINE_WORDS; i++)
			line_data[i] = '0;
		for (int i = 0; i < LINES; i++) begin
			line_tag[i] = '0;
			line_valid[i] = 1'b0;
			line_dirty[i] = 1'b0;
		end
		access_cycles = '0;
		errors = 0;
		responses_checked = 0;
		cycle_count = 0;
		fork
			forever #6 clk = ~clk;
			begin
				repeat (6) @(posedge clk);
				@(negedge clk) arst_n = 1'b1;
			end
		join_none
	end

	// Request driver: bursts with random gaps, optional wait for an idle core
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.func <= FUNC_READ;
			req_ch.address <= '0;
			req_ch.write_data <= '0;
			req_ch.use_cache <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				expected_rsp.push_back(predict_access(cur_word));
			if (req_ch.valid && !req_ch.ready) begin
				offer = 1'b1;
			end else begin
				offer = 1'b0;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_words.size() != 0 &&
						!(pending_words[0].wait_idle && expected_rsp.size() != 0)) begin
					cur_word = pending_words.pop_front();
					burst_left--;
					offer = 1'b1;
					req_ch.func <= cur_word.func;
					req_ch.address <= cur_word.address;
					req_ch.write_data <= cur_word.write_data;
					req_ch.use_cache <= cur_word.use_cache;
				end
			end
			req_ch.valid <= offer;
		end
	end

	// Response ready: segments of stall patterns, one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_mode = STALL_NONE;
			stall_left = 0;
			hold_left = 0;
			hold_done = 1'b0;
		end else begin
			if (!hold_done && responses_checked >= HOLD_OFF_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				if (stall_left == 0) begin
					stall_mode = stall_mode_t'($urandom_range(0, 2));
					stall_left = $urandom_range(8, 64);
				end
				stall_left--;
				case (stall_mode)
					STALL_NONE: rdy = 1'b1;
					STALL_SOME: rdy = 1'($urandom_range(0, 1));
					default: rdy = ($urandom_range(0, 3) == 0);
				endcase
			end
			rsp_ch.ready <= rdy;
		end
	end

	// Response monitor: field-by-field compare against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_rsp.size() == 0) begin
				$display("%0t: response word with none expected: read_data %h hit %b wb %b cyc %0d",
					$time, rsp_ch.read_data, rsp_ch.hit, rsp_ch.wrote_back, rsp_ch.cycle_total);
				errors++;
			end else begin
				automatic response_t e = expected_rsp.pop_front();
				if (rsp_ch.read_data !== e.read_data) begin
					$display("%0t: read_data expected %h actual %h", $time, e.read_data,
						rsp_ch.read_data);
					errors++;
				end
				if (rsp_ch.hit !== e.hit) begin
					$display("%0t: hit expected %b actual %b", $time, e.hit, rsp_ch.hit);
					errors++;
				end
				if (rsp_ch.wrote_back !== e.wrote_back) begin
					$display("%0t: wrote_back expected %b actual %b", $time, e.wrote_back,
						rsp_ch.wrote_back);
					errors++;
				end
				if (rsp_ch.cycle_total !== e.cycle_total) begin
					$display("%0t: cycle_total expected %0d actual %0d", $time, e.cycle_total,
						rsp_ch.cycle_total);
					errors++;
				end
				responses_checked++;
			end
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** direct_mapped_write_back_cache_core: FAILED **");
			$finish;
		end
	end

	// Stimulus and end of run
	initial begin
		automatic logic [ADDR_BITS-1:0] hot [8];
		automatic access_t a;
		// directed: extremes, hits, clean and dirty misses, stale uncached views
		pending_words.push_back(make_access(FUNC_READ, 0, 32'h0, 1'b0, 1'b0));
		pending_words.push_back(make_access(FUNC_WRITE, 255, 32'hffff_ffff, 1'b0, 1'b0));
		pending_words.push_back(make_access(FUNC_READ, 255, 32'h0, 1'b1, 1'b0));
		pending_words.push_back(make_access(FUNC_READ, 252, 32'h0, 1'b1, 1'b0));
		pending_words.push_back(make_access(FUNC_WRITE, 254, 32'h1234_5678, 1'b1, 1'b0));
		pending_words.push_back(make_access(FUNC_READ, 254, 32'h0, 1'b1, 1'b0));
		pending_words.push_back(make_access(FUNC_READ, 254, 32'h0, 1'b0, 1'b0));
		pending_words.push_back(make_access(FUNC_WRITE, 253, 32'hcafe_f00d, 1'b0, 1'b0));
		pending_words.push_back(make_access(FUNC_READ, 253, 32'h0, 1'b1, 1'b0));
		pending_words.push_back(make_access(FUNC_READ, 8'h3c, 32'h0, 1'b1, 1'b0));
		pending_words.push_back(make_access(FUNC_READ, 254, 32'h0, 1'b0, 1'b0));
		pending_words.push_back(make_access(FUNC_READ, 253, 32'h0, 1'b0, 1'b0));
		pending_words.push_back(make_access(FUNC_WRITE, 0, 32'hffff_ffff, 1'b1, 1'b0));
		pending_words.push_back(make_access(FUNC_WRITE, 8'h41, 32'h0, 1'b1, 1'b0));
		pending_words.push_back(make_access(FUNC_WRITE, 8'h82, 32'h5555_aaaa, 1'b1, 1'b0));
		pending_words.push_back(make_access(FUNC_READ, 8'hc3, 32'h0, 1'b1, 1'b0));
		pending_words.push_back(make_access(FUNC_READ, 0, 32'h0, 1'b1, 1'b0));
		pending_words.push_back(make_access(FUNC_WRITE, 0, 32'h0, 1'b0, 1'b1));
		pending_words.push_back(make_access(FUNC_READ, 8'h3c, 32'h0, 1'b1, 1'b0));
		pending_words.push_back(make_access(FUNC_READ, 8'h82, 32'h0, 1'b0, 1'b0));

		// random: mostly cached, half of the addresses from a small hot set
		foreach (hot[i])
			hot[i] = ADDR_BITS'($urandom_range(0, MAIN_DEPTH - 1));
		for (int n = 0; n < RANDOM_ACCESSES; n++) begin
			if ($urandom_range(0, 15) == 0)
				hot[$urandom_range(0, 7)] = ADDR_BITS'($urandom_range(0, MAIN_DEPTH - 1));
			a.func = 1'($urandom_range(0, 1));
			a.use_cache = ($urandom_range(0, 6) != 0);
			a.address = ($urandom_range(0, 1) == 0) ? hot[$urandom_range(0, 7)] :
				ADDR_BITS'($urandom_range(0, MAIN_DEPTH - 1));
			case ($urandom_range(0, 9))
				0: a.write_data = '0;
				1: a.write_data = '1;
				default: a.write_data = $urandom;
			endcase
			a.wait_idle = (n == 300 || n == 900);
			pending_words.push_back(a);
		end

		wait (arst_n);
		do @(posedge clk);
		while (pending_words.size() != 0 || req_ch.valid || expected_rsp.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("** direct_mapped_write_back_cache_core: PASSED **");
		else
			$display("** direct_mapped_write_back_cache_core: FAILED **");
		$finish;
	end

endmodule
